[hw/rtl/qwcc_pkg.sv]
package qwcc_pkg;

  localparam int unsigned SUM_W     = 24;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned OFS_W     = 7;
  localparam int unsigned RAW_W     = 7;
  localparam int unsigned RPOS_W    = 14;
  localparam int unsigned TGT_W     = 12;
  localparam int unsigned BASE_W    = 2;
  localparam int unsigned PHRED_W   = 7;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;
  localparam logic [CNT_W-1:0]        CNT_MAX = 16'hFFFF;

  localparam int PHRED_CAP  = 42;
  localparam int PHRED_BIAS = 33;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;
  localparam logic [OFS_W-1:0] OFS_RESET = 7'd33;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_FINAL = 2'd2
  } opcode_e;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_MOD  = 6'b000100,
    S_WR   = 6'b001000,
    S_EVAL = 6'b010000,
    S_SUM  = 6'b100000
  } state_e;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [RPOS_W-1:0] mag;
    logic [LEN_W-1:0]  len;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] residue;
  } mod_rsp_t;

  typedef struct packed {
    logic [BASE_W-1:0]       consensus_base;
    logic                    no_call;
    logic signed [SUM_W-1:0] consensus_quality;
    logic signed [SUM_W-1:0] alternative_quality;
    logic [CNT_W-1:0]        coverage_depth;
    logic [CNT_W-1:0]        match_count;
    logic [CNT_W-1:0]        mismatch_count;
    logic [PHRED_W-1:0]      phred_char;
  } result_t;

endpackage

[hw/rtl/qwcc_mod.sv]
module qwcc_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qwcc_pkg::mod_req_t req_i,
  output qwcc_pkg::mod_rsp_t rsp_o
);
  import qwcc_pkg::*;

  localparam int unsigned STEP_W = $clog2(RPOS_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q;
  logic [RPOS_W-1:0] mag_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  residue_q;
  logic [LEN_W:0]    rem_sh;
  logic [LEN_W-1:0]  rem_nx;
  logic [LEN_W-1:0]  residue_nx;

  always_comb begin
    rem_sh = {rem_q, mag_q[RPOS_W-1]};
    if (rem_sh >= {1'b0, len_q}) begin
      rem_nx = LEN_W'(rem_sh - {1'b0, len_q});
    end else begin
      rem_nx = rem_sh[LEN_W-1:0];
    end
    if (neg_q && (rem_nx != '0)) begin
      residue_nx = len_q - rem_nx;
    end else begin
      residue_nx = rem_nx;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(RPOS_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.neg;
      mag_q <= req_i.mag;
      len_q <= req_i.len;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      mag_q <= {mag_q[RPOS_W-2:0], 1'b0};
      if (step_q == '0) begin
        residue_q <= residue_nx;
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.residue = residue_q;

endmodule

[hw/rtl/qwcc_table.sv]
module qwcc_table #(
  parameter int unsigned MAX_POSITIONS = 4096,
  parameter int unsigned BASE_COUNT    = 4,
  localparam int unsigned POS_W  = $clog2(MAX_POSITIONS),
  localparam int unsigned SROW_W = BASE_COUNT * qwcc_pkg::SUM_W,
  localparam int unsigned CROW_W = BASE_COUNT * qwcc_pkg::CNT_W
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [POS_W-1:0]  waddr_i,
  input  logic [SROW_W-1:0] wsum_i,
  input  logic [CROW_W-1:0] wcnt_i,
  input  logic              re_i,
  input  logic [POS_W-1:0]  raddr_i,
  output logic [SROW_W-1:0] rsum_o,
  output logic [CROW_W-1:0] rcnt_o
);

  logic [SROW_W-1:0] sum_mem [MAX_POSITIONS];
  logic [CROW_W-1:0] cnt_mem [MAX_POSITIONS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      sum_mem[waddr_i] <= wsum_i;
      cnt_mem[waddr_i] <= wcnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rsum_o <= sum_mem[raddr_i];
      rcnt_o <= cnt_mem[raddr_i];
    end
  end

endmodule

[hw/rtl/quality_weighted_consensus_caller_top.sv]
// Quality-weighted consensus caller over a circular sequence. Each table row holds, for one
// position, a signed 24-bit quality sum and a 16-bit call count per base, in a single-port-write,
// registered-read memory. After reset the block walks the memory once, clearing one row per
// cycle, and stalls input until the walk is done. An add transfer computes the position
// residue in a bit-serial modulo unit that resolves one bit of the 14-bit position difference
// per cycle, followed by a read and a write-back of the row. A finalize steps through row
// read, winner search and result assembly, and waits at result assembly only while the output
// register still holds an untaken result. A clear writes a zero row without leaving idle. Items
// are handled one at a time, so read-modify-write accesses never overlap. Configuration
// registers sit at byte offset 0 (consensus length) and 4 (quality offset).
module quality_weighted_consensus_caller_top #(
  parameter int unsigned MAX_POSITIONS = 4096,
  parameter int unsigned BASE_COUNT    = 4
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [qwcc_pkg::APB_AW-1:0]                paddr,
  input  logic [qwcc_pkg::APB_DW-1:0]                pwdata,
  output logic [qwcc_pkg::APB_DW-1:0]                prdata,
  output logic                                       pready,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic [1:0]                                 opcode_i,
  input  logic [qwcc_pkg::BASE_W-1:0]                base_index_i,
  input  logic [qwcc_pkg::RAW_W-1:0]                 raw_quality_i,
  input  logic [qwcc_pkg::RPOS_W-1:0]                read_pos_i,
  input  logic [qwcc_pkg::RPOS_W-1:0]                break_pos_i,
  input  logic [qwcc_pkg::TGT_W-1:0]                 target_position_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [qwcc_pkg::BASE_W-1:0]                consensus_base_o,
  output logic                                       no_call_o,
  output logic signed [qwcc_pkg::SUM_W-1:0]          consensus_quality_o,
  output logic signed [qwcc_pkg::SUM_W-1:0]          alternative_quality_o,
  output logic [qwcc_pkg::CNT_W-1:0]                 coverage_depth_o,
  output logic [qwcc_pkg::CNT_W-1:0]                 match_count_o,
  output logic [qwcc_pkg::CNT_W-1:0]                 mismatch_count_o,
  output logic [qwcc_pkg::PHRED_W-1:0]               phred_char_o
);
  import qwcc_pkg::*;

  localparam int unsigned POS_W  = $clog2(MAX_POSITIONS);
  localparam int unsigned BIDX_W = $clog2(BASE_COUNT);
  localparam int unsigned SROW_W = BASE_COUNT * SUM_W;
  localparam int unsigned CROW_W = BASE_COUNT * CNT_W;
  localparam int unsigned TSUM_W = SUM_W + BIDX_W + 1;
  localparam int unsigned TCNT_W = CNT_W + BIDX_W;
  localparam int unsigned ACC_W  = SUM_W + 2;

  // configuration
  logic [LEN_W-1:0] cfg_len_q;
  logic [OFS_W-1:0] cfg_ofs_q;
  logic             cfg_we;
  logic [LEN_W-1:0] len_eff;

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LEN_RESET;
      cfg_ofs_q <= OFS_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_LENGTH: cfg_len_q <= pwdata[LEN_W-1:0];
        REG_OFFSET: cfg_ofs_q <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, cfg_len_q};
      REG_OFFSET: prdata = {{(APB_DW-OFS_W){1'b0}}, cfg_ofs_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg_len_q) > MAX_POSITIONS) begin
      len_eff = LEN_W'(MAX_POSITIONS);
    end else begin
      len_eff = cfg_len_q;
    end
  end

  // control
  state_e            state_q, state_d;
  logic [POS_W-1:0]  init_cnt_q, init_cnt_d;
  logic              in_xfer;
  logic              tgt_ok;
  logic              base_ok;
  mod_req_t          mreq;
  mod_rsp_t          mrsp;
  logic              mem_we;
  logic [POS_W-1:0]  mem_waddr;
  logic [SROW_W-1:0] mem_wsum;
  logic [CROW_W-1:0] mem_wcnt;
  logic              mem_re;
  logic [POS_W-1:0]  mem_raddr;
  logic [SROW_W-1:0] mem_rsum;
  logic [CROW_W-1:0] mem_rcnt;
  logic              out_load;

  logic [BIDX_W-1:0] base_q;
  logic [RAW_W-1:0]  rq_q;
  logic [POS_W-1:0]  addr_q;

  logic [SROW_W-1:0] upd_sum;
  logic [CROW_W-1:0] upd_cnt;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign tgt_ok     = ({1'b0, target_position_i} < len_eff);
  assign base_ok    = (32'(base_index_i) < BASE_COUNT);

  always_comb begin
    mreq.start = 1'b0;
    mreq.neg   = (read_pos_i < break_pos_i);
    mreq.mag   = mreq.neg ? (break_pos_i - read_pos_i) : (read_pos_i - break_pos_i);
    mreq.len   = len_eff;
  end

  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    mem_we     = 1'b0;
    mem_waddr  = POS_W'(target_position_i);
    mem_wsum   = '0;
    mem_wcnt   = '0;
    mem_re     = 1'b0;
    mem_raddr  = POS_W'(target_position_i);
    out_load   = 1'b0;
    mreq_start = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = init_cnt_q;
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == POS_W'(MAX_POSITIONS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (opcode_i)
            OP_CLEAR: begin
              mem_we = tgt_ok;
            end
            OP_ADD: begin
              if (base_ok) begin
                mreq_start = 1'b1;
                state_d    = S_MOD;
              end
            end
            OP_FINAL: begin
              if (tgt_ok) begin
                mem_re  = 1'b1;
                state_d = S_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mrsp.done) begin
          mem_re    = 1'b1;
          mem_raddr = POS_W'(mrsp.residue);
          state_d   = S_WR;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wsum  = upd_sum;
        mem_wcnt  = upd_cnt;
        state_d   = S_IDLE;
      end
      S_EVAL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  logic mreq_start;
  mod_req_t mreq_x;

  always_comb begin
    mreq_x       = mreq;
    mreq_x.start = mreq_start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      base_q <= BIDX_W'(base_index_i);
      rq_q   <= raw_quality_i;
    end
    if ((state_q == S_MOD) && mrsp.done) begin
      addr_q <= POS_W'(mrsp.residue);
    end
  end

  qwcc_mod u_qwcc_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_x),
    .rsp_o  (mrsp)
  );

  qwcc_table #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .BASE_COUNT    (BASE_COUNT)
  ) u_qwcc_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wsum_i  (mem_wsum),
    .wcnt_i  (mem_wcnt),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rsum_o  (mem_rsum),
    .rcnt_o  (mem_rcnt)
  );

  // add: modify one lane of the row
  logic [SUM_W-1:0] sel_sum;
  logic [CNT_W-1:0] sel_cnt;
  logic [ACC_W-1:0] acc;
  logic [SUM_W-1:0] new_sum;
  logic [CNT_W-1:0] new_cnt;

  always_comb begin
    sel_sum = mem_rsum[base_q*SUM_W +: SUM_W];
    sel_cnt = mem_rcnt[base_q*CNT_W +: CNT_W];
    acc     = {{2{sel_sum[SUM_W-1]}}, sel_sum}
            + {{(ACC_W-RAW_W){1'b0}}, rq_q}
            - {{(ACC_W-OFS_W){1'b0}}, cfg_ofs_q};
    if ((acc[ACC_W-1:SUM_W-1] == '0) || (acc[ACC_W-1:SUM_W-1] == '1)) begin
      new_sum = acc[SUM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      new_sum = SUM_MIN;
    end else begin
      new_sum = SUM_MAX;
    end
    new_cnt = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
    for (int b = 0; b < BASE_COUNT; b++) begin
      if (BIDX_W'(b) == base_q) begin
        upd_sum[b*SUM_W +: SUM_W] = new_sum;
        upd_cnt[b*CNT_W +: CNT_W] = new_cnt;
      end else begin
        upd_sum[b*SUM_W +: SUM_W] = mem_rsum[b*SUM_W +: SUM_W];
        upd_cnt[b*CNT_W +: CNT_W] = mem_rcnt[b*CNT_W +: CNT_W];
      end
    end
  end

  // finalize: winner search and row totals
  logic                     ev_found;
  logic [BIDX_W-1:0]        ev_widx;
  logic signed [SUM_W-1:0]  ev_qmax;
  logic signed [TSUM_W-1:0] ev_tsum;
  logic [TCNT_W-1:0]        ev_tcnt;
  logic signed [SUM_W-1:0]  lane_sum;

  always_comb begin
    ev_found = 1'b0;
    ev_widx  = '0;
    ev_qmax  = '1;
    ev_tsum  = '0;
    ev_tcnt  = '0;
    lane_sum = '0;
    for (int b = 0; b < BASE_COUNT; b++) begin
      lane_sum = mem_rsum[b*SUM_W +: SUM_W];
      if (lane_sum > ev_qmax) begin
        ev_qmax  = lane_sum;
        ev_widx  = BIDX_W'(b);
        ev_found = 1'b1;
      end
      ev_tsum = ev_tsum + TSUM_W'(lane_sum);
      ev_tcnt = ev_tcnt + TCNT_W'(mem_rcnt[b*CNT_W +: CNT_W]);
    end
  end

  logic                     found_q;
  logic [BIDX_W-1:0]        widx_q;
  logic signed [SUM_W-1:0]  qmax_q;
  logic signed [TSUM_W-1:0] tsum_q;
  logic [TCNT_W-1:0]        tcnt_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EVAL) begin
      found_q <= ev_found;
      widx_q  <= ev_widx;
      qmax_q  <= ev_qmax;
      tsum_q  <= ev_tsum;
      tcnt_q  <= ev_tcnt;
    end
  end

  // finalize: result assembly
  logic [CNT_W-1:0]         mcnt;
  logic signed [TSUM_W-1:0] alt_w;
  logic [TCNT_W-1:0]        mism_w;
  logic [PHRED_W-1:0]       ph;
  result_t                  res_d;

  always_comb begin
    mcnt   = found_q ? mem_rcnt[widx_q*CNT_W +: CNT_W] : '0;
    alt_w  = found_q ? (tsum_q - TSUM_W'(qmax_q)) : tsum_q;
    mism_w = tcnt_q - TCNT_W'(mcnt);
    if (!found_q) begin
      ph = '0;
    end else if (qmax_q > PHRED_CAP) begin
      ph = PHRED_W'(PHRED_CAP);
    end else begin
      ph = qmax_q[PHRED_W-1:0];
    end

    res_d.consensus_base    = BASE_W'(widx_q);
    res_d.no_call           = ~found_q;
    res_d.consensus_quality = qmax_q;
    if (alt_w > TSUM_W'(SUM_MAX)) begin
      res_d.alternative_quality = SUM_MAX;
    end else if (alt_w < TSUM_W'(SUM_MIN)) begin
      res_d.alternative_quality = SUM_MIN;
    end else begin
      res_d.alternative_quality = SUM_W'(alt_w);
    end
    res_d.coverage_depth = (tcnt_q > TCNT_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(tcnt_q);
    res_d.match_count    = mcnt;
    res_d.mismatch_count = (mism_w > TCNT_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(mism_w);
    res_d.phred_char     = ph + PHRED_W'(PHRED_BIAS);
  end

  // output register
  logic    out_valid_q, out_valid_d;
  result_t res_q;

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign consensus_base_o      = res_q.consensus_base;
  assign no_call_o             = res_q.no_call;
  assign consensus_quality_o   = res_q.consensus_quality;
  assign alternative_quality_o = res_q.alternative_quality;
  assign coverage_depth_o      = res_q.coverage_depth;
  assign match_count_o         = res_q.match_count;
  assign mismatch_count_o      = res_q.mismatch_count;
  assign phred_char_o          = res_q.phred_char;

endmodule

[hw/rtl/qwcc_checker.sv]
module qwcc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [qwcc_pkg::BASE_W-1:0]        consensus_base_o,
  input logic                               no_call_o,
  input logic signed [qwcc_pkg::SUM_W-1:0]  consensus_quality_o,
  input logic [qwcc_pkg::CNT_W-1:0]         coverage_depth_o,
  input logic [qwcc_pkg::CNT_W-1:0]         match_count_o,
  input logic [qwcc_pkg::PHRED_W-1:0]       phred_char_o
);
  import qwcc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(consensus_quality_o))
    else $error("stalled result dropped or changed");

  a_no_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_call_o |-> (consensus_base_o == '0) && (consensus_quality_o == -1)
      && (match_count_o == '0) && (phred_char_o == PHRED_W'(PHRED_BIAS)))
    else $error("no-call result fields inconsistent");

  a_call_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_call_o |-> !consensus_quality_o[SUM_W-1]
      && (phred_char_o >= PHRED_W'(PHRED_BIAS))
      && (phred_char_o <= PHRED_W'(PHRED_BIAS + PHRED_CAP)))
    else $error("called base has negative quality or phred out of range");

  a_match_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> match_count_o <= coverage_depth_o)
    else $error("match count exceeds depth");

endmodule

bind quality_weighted_consensus_caller_top qwcc_checker u_qwcc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .consensus_base_o    (consensus_base_o),
  .no_call_o           (no_call_o),
  .consensus_quality_o (consensus_quality_o),
  .coverage_depth_o    (coverage_depth_o),
  .match_count_o       (match_count_o),
  .phred_char_o        (phred_char_o)
);
